>>> sv/lu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_pkg: shared constants and types for the scaled-pivot lu block
// fixed-point limits, saturation helpers, divider request struct and reply struct
// ----------------------------------------------------------------------------
package lu_pkg;

    localparam int MAX_SIZE_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QW            = 32;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;

    // divider request and reply
    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    // saturate a 64-bit value to 32 bits
    function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] v);
        logic signed [QW-1:0] r;
        begin
            if (v > 64'sh000000007fffffff)
                r = Q_MAX;
            else if (v < -64'sh0000000080000000)
                r = Q_MIN;
            else
                r = v[QW-1:0];
            return r;
        end
    endfunction

    // magnitude with saturation
    function automatic logic signed [QW-1:0] mag32(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] r;
        begin
            if (v == Q_MIN)
                r = Q_MAX;
            else if (v < 0)
                r = -v;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

>>> sv/lu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_ram: generic simple dual-port ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> sv/lu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_div: iterative signed divider
// restoring division, one quotient bit a cycle, truncates toward zero, saturates
// ----------------------------------------------------------------------------
module lu_div (
    input  logic             clk,
    input  logic             rst_n,
    input  lu_pkg::div_req_t req,
    output lu_pkg::div_rsp_t rsp
);

    logic [6:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               neg_reg, neg_next;
    logic [63:0]        quo_reg, quo_next;
    logic [64:0]        rem_reg, rem_next;
    logic [31:0]        den_reg, den_next;
    logic [64:0]        trial;
    logic signed [64:0] sq;
    logic [63:0]        nmag;

    always_comb
    begin
        nmag  = req.num[63] ? (~req.num + 64'd1) : req.num;
        trial = {rem_reg[63:0], quo_reg[63]};
        sq    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    end

    // one quotient bit per step
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd64;
            neg_next  = req.num[63] ^ req.den[31];
            quo_next  = nmag;
            rem_next  = '0;
            den_next  = req.den[31] ? (~req.den + 32'd1) : req.den;
        end
        else if (busy_reg)
        begin
            if (trial >= {33'd0, den_reg})
            begin
                rem_next = trial - {33'd0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (quo_reg[63] && !neg_reg)
            rsp.quo = lu_pkg::Q_MAX;
        else
            rsp.quo = lu_pkg::sat32(sq[63:0]);
    end

endmodule

>>> sv/lu_decomposition_scaled_pivot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_decomposition_scaled_pivot: in-place lu factoring with scaled pivoting
// loads an n-by-n q-format matrix, factors it, streams l\u out row-major
// ----------------------------------------------------------------------------
// words load at one per cycle while offered; then the sequencer takes each
// reciprocal or quotient through start, 64 divider steps and finish, each
// multiply-subtract through URD, UMUL, UWR, and each output word, as taken, via ORD, OUT
// throughput: one matrix at a time, no input taken while factoring or emitting
// reset: asynchronous active low, size returns to 8, load count and tables clear
module lu_decomposition_scaled_pivot #(
    parameter int MAX_SIZE  = lu_pkg::MAX_SIZE_DEF,
    parameter int FRAC_BITS = lu_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,        // matrix_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // element_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,    // row_index, column_index, factor_value, pivot_row
    output logic        m_axis_tuser,    // singular
    output logic        m_axis_tlast     // last
);

    localparam int AW   = $clog2(MAX_SIZE);
    localparam int MAW  = 2 * AW;
    localparam int MD   = MAX_SIZE * MAX_SIZE;

    // sequencer codes
    localparam logic [4:0] S_LOAD  = 5'd0;
    localparam logic [4:0] S_SRD   = 5'd1;
    localparam logic [4:0] S_SCH   = 5'd2;
    localparam logic [4:0] S_SDIV  = 5'd3;
    localparam logic [4:0] S_PRD   = 5'd4;
    localparam logic [4:0] S_PCH   = 5'd5;
    localparam logic [4:0] S_SWA   = 5'd6;
    localparam logic [4:0] S_SWB   = 5'd7;
    localparam logic [4:0] S_SWC   = 5'd8;
    localparam logic [4:0] S_PVRD  = 5'd9;
    localparam logic [4:0] S_PVCH  = 5'd10;
    localparam logic [4:0] S_FRD   = 5'd11;
    localparam logic [4:0] S_FDIV  = 5'd12;
    localparam logic [4:0] S_URD   = 5'd13;
    localparam logic [4:0] S_UMUL  = 5'd14;
    localparam logic [4:0] S_UWR   = 5'd15;
    localparam logic [4:0] S_ORD   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;
    localparam logic [4:0] S_SING  = 5'd18;
    localparam logic [4:0] S_UARD  = 5'd19;
    localparam logic [4:0] S_PCHW  = 5'd20;

    logic [4:0]  st_reg, st_next;
    logic [3:0]  size_reg, size_next;
    logic [AW:0] n;
    logic [AW:0] li_reg, li_next, lj_reg, lj_next;
    logic [AW:0] k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [AW:0] im_reg, im_next;
    logic signed [31:0] big_reg, big_next;
    logic signed [31:0] fa_reg, fa_next, ta_reg, ta_next;
    logic signed [63:0] prod_reg;
    logic signed [31:0] scale_reg [MAX_SIZE];
    logic [AW-1:0]      piv_reg [MAX_SIZE];
    logic               sc_we, pv_we;
    logic [AW-1:0]      sc_wa;
    logic signed [31:0] sc_wd;

    // ram port
    logic               we;
    logic [MAW-1:0]     wa, ra;
    logic [31:0]        wd, rd;

    lu_pkg::div_req_t dreq;
    lu_pkg::div_rsp_t drsp;

    // shared multiplier operands
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod_fl;
    logic signed [31:0] qm;

    // output register
    logic        ov_reg, ov_next;
    logic [47:0] od_reg, od_next;
    logic        ou_reg, ou_next, ol_reg, ol_next;

    lu_ram #(.WIDTH(32), .DEPTH(MD)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(wa),
        .wdata(wd),
        .raddr(ra),
        .rdata(rd)
    );

    lu_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    // effective size
    always_comb
    begin
        if (size_reg == 4'd0)
            n = (AW+1)'(1);
        else if (size_reg > 4'(MAX_SIZE))
            n = (AW+1)'(MAX_SIZE);
        else
            n = size_reg[AW:0];
    end

    function automatic logic [MAW-1:0] adr(input logic [AW:0] r, input logic [AW:0] c);
        return {r[AW-1:0], c[AW-1:0]};
    endfunction

    // floor product in q format
    always_comb
    begin
        prod_fl = prod_reg >>> FRAC_BITS;
        qm      = lu_pkg::sat32(prod_fl);
    end

    assign cfg_ready     = (st_reg == S_LOAD);
    assign s_axis_tready = (st_reg == S_LOAD) && !cfg_valid;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

    // sequencer
    always_comb
    begin
        st_next   = st_reg;
        size_next = size_reg;
        li_next   = li_reg;
        lj_next   = lj_reg;
        k_next    = k_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        im_next   = im_reg;
        big_next  = big_reg;
        fa_next   = fa_reg;
        ta_next   = ta_reg;
        we        = 1'b0;
        wa        = '0;
        wd        = '0;
        ra        = '0;
        dreq      = '0;
        ma        = '0;
        mb        = '0;
        sc_we     = 1'b0;
        sc_wa     = '0;
        sc_wd     = '0;
        pv_we     = 1'b0;
        ov_next   = ov_reg;
        od_next   = od_reg;
        ou_next   = ou_reg;
        ol_next   = ol_reg;
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;
        case (st_reg)
            S_LOAD:
            begin
                if (cfg_valid)
                begin
                    size_next = cfg_data;
                    li_next   = '0;
                    lj_next   = '0;
                end
                else if (s_axis_tvalid)
                begin
                    we = 1'b1;
                    wa = adr(li_reg, lj_reg);
                    wd = s_axis_tdata;
                    if (lj_reg == n - 1)
                    begin
                        lj_next = '0;
                        if (li_reg == n - 1)
                        begin
                            li_next  = '0;
                            i_next   = '0;
                            j_next   = '0;
                            big_next = '0;
                            fa_next  = '0;
                            st_next  = S_SRD;
                        end
                        else
                            li_next = li_reg + 1'b1;
                    end
                    else
                        lj_next = lj_reg + 1'b1;
                end
            end
            // row maxima and reciprocal scales
            S_SRD:
            begin
                ra      = adr(i_reg, j_reg);
                st_next = S_SCH;
            end
            S_SCH:
            begin
                if (lu_pkg::mag32(rd) > big_reg)
                    big_next = lu_pkg::mag32(rd);
                if (j_reg == n - 1)
                    st_next = S_SDIV;
                else
                begin
                    j_next  = j_reg + 1'b1;
                    st_next = S_SRD;
                end
            end
            S_SDIV:
            begin
                if (big_reg == 0)
                    st_next = S_SING;
                else if (!drsp.busy && !drsp.done && !fa_reg[0])
                begin
                    dreq.start = 1'b1;
                    dreq.num   = 64'sd1 <<< (2 * FRAC_BITS);
                    dreq.den   = big_reg;
                    fa_next    = 32'sd1;
                end
                else if (drsp.done)
                begin
                    fa_next = '0;
                    sc_we   = 1'b1;
                    sc_wa   = i_reg[AW-1:0];
                    sc_wd   = drsp.quo;
                    big_next = '0;
                    j_next   = '0;
                    if (i_reg == n - 1)
                    begin
                        k_next  = '0;
                        i_next  = '0;
                        st_next = S_PRD;
                    end
                    else
                    begin
                        i_next  = i_reg + 1'b1;
                        st_next = S_SRD;
                    end
                end
            end
            S_SING:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    od_next = {7'd0, 3'd0, 32'd0, 3'd0, 3'(i_reg)};
                    ou_next = 1'b1;
                    ol_next = 1'b1;
                    st_next = S_LOAD;
                end
            end
            // pivot search over column k
            S_PRD:
            begin
                if (i_reg == '0)
                begin
                    i_next   = k_reg;
                    im_next  = k_reg;
                    big_next = '0;
                    ra       = adr(k_reg, k_reg);
                end
                else
                    ra = adr(i_reg, k_reg);
                st_next = S_PCH;
            end
            S_PCH:
            begin
                ma      = scale_reg[i_reg[AW-1:0]];
                mb      = lu_pkg::mag32(rd);
                st_next = S_PCHW;
            end
            S_PCHW:
            begin
                if (qm > big_reg)
                begin
                    big_next = qm;
                    im_next  = i_reg;
                end
                if (i_reg == n - 1)
                begin
                    j_next  = '0;
                    st_next = (im_next != k_reg) ? S_SWA : S_PVRD;
                    if (im_next != k_reg)
                    begin
                        sc_we = 1'b1;
                        sc_wa = im_next[AW-1:0];
                        sc_wd = scale_reg[k_reg[AW-1:0]];
                    end
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    st_next = S_PRD;
                end
            end
            // row swap, one column at a time
            S_SWA:
            begin
                ra      = adr(k_reg, j_reg);
                st_next = S_SWB;
            end
            S_SWB:
            begin
                ta_next = rd;
                ra      = adr(im_reg, j_reg);
                st_next = S_SWC;
            end
            S_SWC:
            begin
                we = 1'b1;
                wa = adr(k_reg, j_reg);
                wd = rd;
                fa_next = ta_reg;
                if (j_reg == n)
                begin
                    j_next  = '0;
                    st_next = S_PVRD;
                end
                else
                    st_next = S_UARD;
            end
            S_UARD:
            begin
                we = 1'b1;
                wa = adr(im_reg, j_reg);
                wd = fa_reg;
                if (j_reg == n - 1)
                begin
                    j_next  = '0;
                    st_next = S_PVRD;
                end
                else
                begin
                    j_next  = j_reg + 1'b1;
                    st_next = S_SWA;
                end
            end
            // record pivot and guard zero pivot
            S_PVRD:
            begin
                pv_we   = 1'b1;
                ra      = adr(k_reg, k_reg);
                st_next = S_PVCH;
            end
            S_PVCH:
            begin
                if (rd == 32'd0)
                begin
                    we = 1'b1;
                    wa = adr(k_reg, k_reg);
                    wd = 32'd1;
                    ta_next = 32'sd1;
                end
                else
                    ta_next = rd;
                i_next = k_reg + 1'b1;
                if (k_reg == n - 1)
                begin
                    i_next  = '0;
                    j_next  = '0;
                    st_next = S_ORD;
                end
                else
                    st_next = S_FRD;
            end
            // multiplier for row i
            S_FRD:
            begin
                ra      = adr(i_reg, k_reg);
                fa_next = '0;
                st_next = S_FDIV;
            end
            S_FDIV:
            begin
                if (!drsp.busy && !drsp.done && !fa_reg[0])
                begin
                    dreq.start = 1'b1;
                    dreq.num   = 64'(signed'(rd)) <<< FRAC_BITS;
                    dreq.den   = ta_reg;
                    fa_next    = 32'sd1;
                end
                else if (drsp.done)
                begin
                    fa_next = drsp.quo;
                    we      = 1'b1;
                    wa      = adr(i_reg, k_reg);
                    wd      = drsp.quo;
                    j_next  = k_reg + 1'b1;
                    st_next = S_URD;
                end
            end
            // update row i, column j
            S_URD:
            begin
                ra      = adr(k_reg, j_reg);
                st_next = S_UMUL;
            end
            S_UMUL:
            begin
                ma      = fa_reg;
                mb      = rd;
                ra      = adr(i_reg, j_reg);
                st_next = S_UWR;
            end
            S_UWR:
            begin
                we = 1'b1;
                wa = adr(i_reg, j_reg);
                wd = lu_pkg::sat32(64'(signed'(rd)) - 64'(qm));
                if (j_reg == n - 1)
                begin
                    if (i_reg == n - 1)
                    begin
                        k_next  = k_reg + 1'b1;
                        i_next  = '0;
                        st_next = S_PRD;
                    end
                    else
                    begin
                        i_next  = i_reg + 1'b1;
                        st_next = S_FRD;
                    end
                end
                else
                begin
                    j_next  = j_reg + 1'b1;
                    st_next = S_URD;
                end
            end
            // stream out
            S_ORD:
            begin
                ra      = adr(i_reg, j_reg);
                st_next = S_OUT;
            end
            S_OUT:
            begin
                // keep the element on the read port while the output stalls
                ra = adr(i_reg, j_reg);
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {7'd0, 3'(piv_reg[i_reg[AW-1:0]]), rd, 3'(j_reg), 3'(i_reg)};
                    ou_next = 1'b0;
                    ol_next = (i_reg == n - 1) && (j_reg == n - 1);
                    st_next = S_ORD;
                    if (j_reg == n - 1)
                    begin
                        j_next = '0;
                        if (i_reg == n - 1)
                            st_next = S_LOAD;
                        else
                            i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            default:
                st_next = S_LOAD;
        endcase
    end

    // the update step enters UWR with i>=k+1; the last j wraps row i
    // note: when k reaches n-1 via PRD the search loop handles single row

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_LOAD;
            size_reg <= 4'd8;
            li_reg   <= '0;
            lj_reg   <= '0;
            k_reg    <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            im_reg   <= '0;
            big_reg  <= '0;
            fa_reg   <= '0;
            ov_reg   <= 1'b0;
            for (int q = 0; q < MAX_SIZE; q++)
            begin
                scale_reg[q] <= '0;
                piv_reg[q]   <= '0;
            end
        end
        else
        begin
            st_reg   <= st_next;
            size_reg <= size_next;
            li_reg   <= li_next;
            lj_reg   <= lj_next;
            k_reg    <= k_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            im_reg   <= im_next;
            big_reg  <= big_next;
            fa_reg   <= fa_next;
            ov_reg   <= ov_next;
            if (sc_we)
                scale_reg[sc_wa] <= sc_wd;
            if (pv_we)
                piv_reg[k_reg[AW-1:0]] <= im_reg[AW-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ta_reg   <= ta_next;
        prod_reg <= ma * mb;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
        ol_reg   <= ol_next;
    end

endmodule

>>> sv/lu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_checker: port-level checks for the lu block
// watches handshakes and framing on the stream ports
// ----------------------------------------------------------------------------
module lu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // a singular word is always the last one
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("singular word without last");

    // no input taken while a non-final result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open during output run");

endmodule

bind lu_decomposition_scaled_pivot lu_checker u_lu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
